// File: hdl/bhq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bhq_pkg;

   // Field widths of the command and result channels
   localparam int CMD_W     = 2;
   localparam int COST_W    = 32;
   localparam int PAYLOAD_W = 16;
   localparam int STATUS_W  = 2;
   localparam int FILL_W    = 9;

   // Default number of heap entries
   localparam int DEF_CAPACITY = 256;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // One heap entry as stored in memory
   typedef struct packed {
      logic [COST_W-1:0]    cost;
      logic [PAYLOAD_W-1:0] payload;
   } entry_type;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_UP_RD,
      S_UP_CMP,
      S_POP_RD,
      S_POP_LD,
      S_DN_RD,
      S_DN_CMP
   } state_type;

endpackage

`default_nettype wire

// File: hdl/binary_min_heap_queue_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Binary min-heap priority queue of (cost, payload) entries.
// Command channel: req_cmd, req_cost and req_payload transfer at a rising edge
// with start high and busy low. Commands are push, pop minimum and clear.
// Result channel: one result per command, shown for exactly one cycle with
// rsp_valid high: status, popped payload and cost, and the fill after the
// command. The receiver cannot stall; each result is taken in its cycle.
// Clear, rejected push, pop on empty and unused codes answer in the cycle after
// the transfer. A push climbs from the new slot one level at a time and settles
// at the root or where the parent is no dearer. A pop reads the root and the
// last entry and ends there when it removed the last entry, else it sinks that
// entry one level at a time until it has no child or no child is cheaper. Each level costs
// one registered read of the entry memory and one compare with write-back; one
// command is in flight at a time and busy stays high until its result strobe.
// Reset empties the heap at once; the memory itself is not cleared, since only
// entries below the fill count are ever used.
module binary_min_heap_queue_unit #(
   parameter int CAPACITY = bhq_pkg::DEF_CAPACITY
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [bhq_pkg::CMD_W-1:0]      req_cmd,
   input  wire logic [bhq_pkg::COST_W-1:0]     req_cost,
   input  wire logic [bhq_pkg::PAYLOAD_W-1:0]  req_payload,
   output logic                                rsp_valid,
   output logic [bhq_pkg::STATUS_W-1:0]        rsp_status,
   output logic [bhq_pkg::PAYLOAD_W-1:0]       rsp_out_payload,
   output logic [bhq_pkg::COST_W-1:0]          rsp_out_cost,
   output logic [bhq_pkg::FILL_W-1:0]          rsp_fill
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = AW + 2;

   // Entry memory, two registered read ports, one write port
   bhq_pkg::entry_type mem [CAPACITY];
   bhq_pkg::entry_type rd_a_ff;
   bhq_pkg::entry_type rd_b_ff;
   logic [AW-1:0]      rd_a_addr;
   logic [AW-1:0]      rd_b_addr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   bhq_pkg::entry_type wr_data;

   // Control and datapath registers
   bhq_pkg::state_type            state_ff, state_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [AW-1:0]                 pos_ff, pos_in;
   bhq_pkg::entry_type            cur_ff, cur_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [bhq_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [bhq_pkg::PAYLOAD_W-1:0] rsp_payload_ff, rsp_payload_in;
   logic [bhq_pkg::COST_W-1:0]    rsp_cost_ff, rsp_cost_in;

   // Decision signals
   logic                          accept;
   logic                          full;
   logic                          empty;
   logic [AW-1:0]                 parent;
   logic [XW-1:0]                 lft;
   logic [XW-1:0]                 rgt;
   logic [XW-1:0]                 count_x;
   logic                          lft_ok;
   logic                          rgt_ok;
   logic                          up_win;
   logic                          left_win;
   logic                          right_win;
   logic [bhq_pkg::COST_W-1:0]    best_cost;
   logic                          moved;
   logic [XW-1:0]                 child;
   bhq_pkg::entry_type            child_entry;
   logic [CW+bhq_pkg::FILL_W-1:0] fill_ext;

   assign accept    = start && !busy;
   assign full      = (count_ff == CW'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign parent    = (pos_ff - AW'(1)) >> 1;
   assign lft       = (XW'(pos_ff) << 1) + XW'(1);
   assign rgt       = (XW'(pos_ff) << 1) + XW'(2);
   assign count_x   = XW'(count_ff);
   assign lft_ok    = (lft < count_x);
   assign rgt_ok    = (rgt < count_x);
   assign up_win    = (cur_ff.cost < rd_a_ff.cost);
   assign left_win  = lft_ok && (rd_a_ff.cost < cur_ff.cost);
   assign best_cost = left_win ? rd_a_ff.cost : cur_ff.cost;
   assign right_win = rgt_ok && (rd_b_ff.cost < best_cost);
   assign moved     = left_win || right_win;
   assign child       = right_win ? rgt : lft;
   assign child_entry = right_win ? rd_b_ff : rd_a_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bhq_pkg::S_IDLE: begin
            if (accept) begin
               if (req_cmd == bhq_pkg::CMD_PUSH && !full) begin
                  state_in = bhq_pkg::S_UP_RD;
               end else if (req_cmd == bhq_pkg::CMD_POP && !empty) begin
                  state_in = bhq_pkg::S_POP_RD;
               end
            end
         end
         bhq_pkg::S_UP_RD: begin
            state_in = (pos_ff == '0) ? bhq_pkg::S_IDLE : bhq_pkg::S_UP_CMP;
         end
         bhq_pkg::S_UP_CMP: begin
            state_in = up_win ? bhq_pkg::S_UP_RD : bhq_pkg::S_IDLE;
         end
         bhq_pkg::S_POP_RD: begin
            state_in = bhq_pkg::S_POP_LD;
         end
         bhq_pkg::S_POP_LD: begin
            state_in = empty ? bhq_pkg::S_IDLE : bhq_pkg::S_DN_RD;
         end
         bhq_pkg::S_DN_RD: begin
            state_in = lft_ok ? bhq_pkg::S_DN_CMP : bhq_pkg::S_IDLE;
         end
         bhq_pkg::S_DN_CMP: begin
            state_in = moved ? bhq_pkg::S_DN_RD : bhq_pkg::S_IDLE;
         end
         default: begin
            state_in = bhq_pkg::S_IDLE;
         end
      endcase
   end

   // Datapath, memory controls and result
   always_comb begin
      count_in       = count_ff;
      pos_in         = pos_ff;
      cur_in         = cur_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_cost_in    = rsp_cost_ff;
      rd_a_addr      = parent;
      rd_b_addr      = rgt[AW-1:0];
      wr_en          = 1'b0;
      wr_addr        = pos_ff;
      wr_data        = cur_ff;
      unique case (state_ff)
         bhq_pkg::S_IDLE: begin
            if (accept) begin
               rsp_status_in  = bhq_pkg::ST_OK;
               rsp_payload_in = '0;
               rsp_cost_in    = '0;
               unique case (req_cmd)
                  bhq_pkg::CMD_PUSH: begin
                     if (full) begin
                        rsp_status_in = bhq_pkg::ST_FULL;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        pos_in         = count_ff[AW-1:0];
                        count_in       = count_ff + CW'(1);
                        cur_in.cost    = req_cost;
                        cur_in.payload = req_payload;
                     end
                  end
                  bhq_pkg::CMD_POP: begin
                     if (empty) begin
                        rsp_status_in = bhq_pkg::ST_EMPTY;
                        rsp_cost_in   = '1;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        count_in = count_ff - CW'(1);
                     end
                  end
                  bhq_pkg::CMD_CLEAR: begin
                     count_in     = '0;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         bhq_pkg::S_UP_RD: begin
            // Read the parent, or settle at the root
            rd_a_addr = parent;
            if (pos_ff == '0) begin
               wr_en        = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         bhq_pkg::S_UP_CMP: begin
            // Move the parent down into the hole, or drop the new entry in
            wr_en = 1'b1;
            if (up_win) begin
               wr_data = rd_a_ff;
               pos_in  = parent;
            end else begin
               rsp_valid_in = 1'b1;
            end
         end
         bhq_pkg::S_POP_RD: begin
            // Fetch the root and the last entry
            rd_a_addr = '0;
            rd_b_addr = count_ff[AW-1:0];
         end
         bhq_pkg::S_POP_LD: begin
            rsp_payload_in = rd_a_ff.payload;
            rsp_cost_in    = rd_a_ff.cost;
            cur_in         = rd_b_ff;
            pos_in         = '0;
            if (empty) begin
               rsp_valid_in = 1'b1;
            end
         end
         bhq_pkg::S_DN_RD: begin
            // Read both children, or settle when there are none
            rd_a_addr = lft[AW-1:0];
            rd_b_addr = rgt[AW-1:0];
            if (!lft_ok) begin
               wr_en        = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         bhq_pkg::S_DN_CMP: begin
            // Lift the smaller child into the hole, or drop the entry in
            wr_en = 1'b1;
            if (moved) begin
               wr_data = child_entry;
               pos_in  = child[AW-1:0];
            end else begin
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // Entry memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_a_addr];
      rd_b_ff <= mem[rd_b_addr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bhq_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      cur_ff         <= cur_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_cost_ff    <= rsp_cost_in;
   end

   // Outputs
   assign busy            = (state_ff != bhq_pkg::S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_out_payload = rsp_payload_ff;
   assign rsp_out_cost    = rsp_cost_ff;
   assign fill_ext        = {{bhq_pkg::FILL_W{1'b0}}, count_ff};
   assign rsp_fill        = fill_ext[bhq_pkg::FILL_W-1:0];

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == bhq_pkg::S_IDLE))
      else $error("result strobe while a command is still running");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_valid_ff))
      else $error("transfer neither started work nor answered");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (CW'(wr_addr) < count_ff))
      else $error("write beyond the held entries");

   a_full_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == bhq_pkg::ST_FULL) |-> full)
      else $error("full status while heap not full");

endmodule

`default_nettype wire

// File: dv/heap_checker.sv
`timescale 1ns / 1ps

module heap_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic                           busy,
   input  wire logic [bhq_pkg::CMD_W-1:0]      req_cmd,
   input  wire logic [bhq_pkg::COST_W-1:0]     req_cost,
   input  wire logic [bhq_pkg::PAYLOAD_W-1:0]  req_payload,
   input  wire logic                           rsp_valid,
   input  wire logic [bhq_pkg::STATUS_W-1:0]   rsp_status,
   input  wire logic [bhq_pkg::PAYLOAD_W-1:0]  rsp_out_payload,
   input  wire logic [bhq_pkg::COST_W-1:0]     rsp_out_cost,
   input  wire logic [bhq_pkg::FILL_W-1:0]     rsp_fill,
   output int                                  fail_count,
   output int                                  pending
);

   localparam int HEAP_DEPTH = bhq_pkg::DEF_CAPACITY;

   // One predicted answer of the queue
   typedef struct packed {
      logic [bhq_pkg::STATUS_W-1:0]  status;
      logic [bhq_pkg::PAYLOAD_W-1:0] payload;
      logic [bhq_pkg::COST_W-1:0]    cost;
      logic [bhq_pkg::FILL_W-1:0]    fill;
   } heap_answer_type;

   bhq_pkg::entry_type heap_mem [HEAP_DEPTH];
   int                 heap_fill = 0;
   heap_answer_type    answer_q [$];
   int                 mismatches = 0;
   int                 waiting = 0;

   assign fail_count = mismatches;
   assign pending    = waiting;

   // Print one line per mismatch and count it
   task automatic report_mismatch(input string msg);
      $display("ERROR %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   // Swap two heap slots
   function automatic void swap_entries(input int a, input int b);
      bhq_pkg::entry_type tmp;
      tmp         = heap_mem[a];
      heap_mem[a] = heap_mem[b];
      heap_mem[b] = tmp;
   endfunction

   // Apply one command to the shadow heap and return the answer it yields
   function automatic heap_answer_type apply_heap_cmd(
      input logic [bhq_pkg::CMD_W-1:0]     op,
      input logic [bhq_pkg::COST_W-1:0]    c,
      input logic [bhq_pkg::PAYLOAD_W-1:0] p);
      heap_answer_type ans;
      int              pos;
      int              up;
      int              lft;
      int              rgt;
      int              best;
      ans = '0;
      case (op)
         bhq_pkg::CMD_PUSH: begin
            if (heap_fill >= HEAP_DEPTH) begin
               ans.status = bhq_pkg::ST_FULL;
            end else begin
               pos = heap_fill;
               heap_fill++;
               heap_mem[pos].cost    = c;
               heap_mem[pos].payload = p;
               // climb while strictly cheaper than the parent
               while (pos != 0) begin
                  up = (pos - 1) / 2;
                  if (heap_mem[pos].cost < heap_mem[up].cost) begin
                     swap_entries(pos, up);
                     pos = up;
                  end else begin
                     break;
                  end
               end
            end
         end
         bhq_pkg::CMD_POP: begin
            if (heap_fill == 0) begin
               ans.status = bhq_pkg::ST_EMPTY;
               ans.cost   = '1;
            end else begin
               ans.cost    = heap_mem[0].cost;
               ans.payload = heap_mem[0].payload;
               heap_fill--;
               heap_mem[0] = heap_mem[heap_fill];
               pos = 0;
               // sink: left child wins on strict less, right must beat the pick
               while (pos < heap_fill) begin
                  lft  = 2 * pos + 1;
                  rgt  = 2 * pos + 2;
                  best = pos;
                  if (lft < heap_fill && heap_mem[lft].cost < heap_mem[pos].cost)
                     best = lft;
                  if (rgt < heap_fill && heap_mem[rgt].cost < heap_mem[best].cost)
                     best = rgt;
                  if (best == pos)
                     break;
                  swap_entries(pos, best);
                  pos = best;
               end
            end
         end
         bhq_pkg::CMD_CLEAR: begin
            heap_fill = 0;
         end
         default: begin
         end
      endcase
      ans.fill = heap_fill[bhq_pkg::FILL_W-1:0];
      return ans;
   endfunction

   // Match each result strobe against the oldest prediction, then log new transfers
   always @(posedge clock) begin
      heap_answer_type want;
      if (reset) begin
         heap_fill = 0;
         answer_q.delete();
      end else begin
         if (rsp_valid) begin
            if (answer_q.size() == 0) begin
               report_mismatch($sformatf("result with no command waiting: status %0d fill %0d",
                                         rsp_status, rsp_fill));
            end else begin
               want = answer_q.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_status, want.status));
               if (rsp_out_payload !== want.payload)
                  report_mismatch($sformatf("out_payload got %h want %h",
                                            rsp_out_payload, want.payload));
               if (rsp_out_cost !== want.cost)
                  report_mismatch($sformatf("out_cost got %h want %h",
                                            rsp_out_cost, want.cost));
               if (rsp_fill !== want.fill)
                  report_mismatch($sformatf("fill got %0d want %0d",
                                            rsp_fill, want.fill));
            end
         end
         if (start && !busy)
            answer_q.push_back(apply_heap_cmd(req_cmd, req_cost, req_payload));
      end
      waiting = answer_q.size();
   end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

   // Code the queue answers without any action
   localparam logic [bhq_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic [bhq_pkg::CMD_W-1:0]     req_cmd = bhq_pkg::CMD_PUSH;
   logic [bhq_pkg::COST_W-1:0]    req_cost = '0;
   logic [bhq_pkg::PAYLOAD_W-1:0] req_payload = '0;
   logic                          busy;
   logic                          rsp_valid;
   logic [bhq_pkg::STATUS_W-1:0]  rsp_status;
   logic [bhq_pkg::PAYLOAD_W-1:0] rsp_out_payload;
   logic [bhq_pkg::COST_W-1:0]    rsp_out_cost;
   logic [bhq_pkg::FILL_W-1:0]    rsp_fill;
   int                            fail_count;
   int                            pending;

   bit                            idle_on = 1'b1;
   int                            fill_guess = 0;
   int                            push_pct;
   int                            roll;

   binary_min_heap_queue_unit uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_cost        (req_cost),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_out_payload (rsp_out_payload),
      .rsp_out_cost    (rsp_out_cost),
      .rsp_fill        (rsp_fill)
   );

   heap_checker heap_chk (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_cost        (req_cost),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_out_payload (rsp_out_payload),
      .rsp_out_cost    (rsp_out_cost),
      .rsp_fill        (rsp_fill),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Draw a cost: tied fixed-point values, small integers, extremes or anything
   function automatic logic [bhq_pkg::COST_W-1:0] pick_cost();
      case ($urandom_range(3))
         0: return 32'($urandom_range(7)) << 16;
         1: return 32'($urandom_range(40));
         2: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
         default: return $urandom;
      endcase
   endfunction

   // Present one command, with optional idle cycles first, and hold until transfer
   task automatic issue_cmd(input logic [bhq_pkg::CMD_W-1:0] op,
                            input logic [bhq_pkg::COST_W-1:0] c,
                            input logic [bhq_pkg::PAYLOAD_W-1:0] p);
      if (idle_on) begin
         while ($urandom_range(99) < 8) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start       <= 1'b1;
      req_cmd     <= op;
      req_cost    <= c;
      req_payload <= p;
      do @(posedge clock); while (busy);
      // rough fill track, only to steer the command mix
      case (op)
         bhq_pkg::CMD_PUSH:  if (fill_guess < bhq_pkg::DEF_CAPACITY) fill_guess++;
         bhq_pkg::CMD_POP:   if (fill_guess > 0) fill_guess--;
         bhq_pkg::CMD_CLEAR: fill_guess = 0;
         default:   ;
      endcase
   endtask

   // Drop start and hold until every predicted result has come back
   task automatic drain_results();
      start <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pop, spare code, cost extremes, ties, clear
      issue_cmd(bhq_pkg::CMD_POP, 32'h0, 16'h0);
      issue_cmd(CMD_SPARE, 32'hFFFF_FFFF, 16'hFFFF);
      issue_cmd(bhq_pkg::CMD_PUSH, 32'hFFFF_FFFF, 16'hFFFF);
      issue_cmd(bhq_pkg::CMD_PUSH, 32'h0, 16'h0);
      issue_cmd(bhq_pkg::CMD_PUSH, 32'h0001_0000, 16'h1234);
      issue_cmd(bhq_pkg::CMD_PUSH, 32'h0001_0000, 16'h0001);
      issue_cmd(bhq_pkg::CMD_PUSH, 32'h0001_0000, 16'h0002);
      issue_cmd(CMD_SPARE, 32'h0, 16'h0);
      repeat (6) issue_cmd(bhq_pkg::CMD_POP, 32'h0, 16'h0);
      issue_cmd(bhq_pkg::CMD_PUSH, 32'h8000_0000, 16'h8000);
      issue_cmd(bhq_pkg::CMD_PUSH, 32'h7FFF_FFFF, 16'h7FFF);
      issue_cmd(bhq_pkg::CMD_PUSH, 32'h0000_0001, 16'hAAAA);
      issue_cmd(bhq_pkg::CMD_CLEAR, 32'hFFFF_FFFF, 16'hFFFF);
      issue_cmd(bhq_pkg::CMD_POP, 32'h0, 16'h0);
      issue_cmd(bhq_pkg::CMD_PUSH, 32'h5555_5555, 16'h5555);
      issue_cmd(bhq_pkg::CMD_POP, 32'h0, 16'h0);

      // fill to capacity, overrun it, then empty it and underrun
      drain_results();
      issue_cmd(bhq_pkg::CMD_CLEAR, $urandom, 16'($urandom));
      repeat (bhq_pkg::DEF_CAPACITY + 3)
         issue_cmd(bhq_pkg::CMD_PUSH, pick_cost(), 16'($urandom));
      drain_results();
      repeat (bhq_pkg::DEF_CAPACITY + 3)
         issue_cmd(bhq_pkg::CMD_POP, $urandom, 16'($urandom));

      // random mix, push bias swinging so the heap grows deep and shrinks
      for (int k = 0; k < 1000; k++) begin
         idle_on  = !(k >= 300 && k < 550);
         push_pct = ((k / 120) % 2 == 0) ? 70 : 36;
         if ($urandom_range(199) == 0)
            drain_results();
         roll = $urandom_range(99);
         if (roll < 2)
            issue_cmd(CMD_SPARE, $urandom, 16'($urandom));
         else if (roll < 4 || (roll < 8 && fill_guess > 200))
            issue_cmd(bhq_pkg::CMD_CLEAR, $urandom, 16'($urandom));
         else if (roll < 4 + push_pct)
            issue_cmd(bhq_pkg::CMD_PUSH, pick_cost(), 16'($urandom));
         else
            issue_cmd(bhq_pkg::CMD_POP, $urandom, 16'($urandom));
      end

      // let the last results land
      drain_results();
      repeat (30) @(posedge clock);
      if (fail_count == 0)
         $display("binary_min_heap_queue_unit test passed");
      else
         $display("binary_min_heap_queue_unit test failed");
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("binary_min_heap_queue_unit test failed");
      $finish;
   end

endmodule
